// ----- rtl/vcc_pkg.sv -----
// ----------------------------------------------------------------------------
// vcc_pkg
// Types and constants shared by the vending credit controller modules.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned COIN_W     = 10;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned QTY_W      = 7;
  localparam int unsigned PRICE_W    = 10;
  localparam int unsigned REPORT_W   = 16;

  localparam logic [COIN_W-1:0]   COIN_LIMIT  = 10'd500;
  localparam logic [REPORT_W-1:0] REPORT_MAX  = 16'hFFFF;

  localparam logic [SLOT_W-1:0]   SLOT_NONE   = 2'd0;
  localparam logic [SLOT_W-1:0]   SLOT_ONE    = 2'd1;
  localparam logic [SLOT_W-1:0]   SLOT_TWO    = 2'd2;

  localparam logic [QTY_W-1:0]    STOCK_ONE_RESET = 7'd10;
  localparam logic [QTY_W-1:0]    STOCK_TWO_RESET = 7'd15;
  localparam logic [PRICE_W-1:0]  COST_ONE_RESET  = 10'd100;
  localparam logic [PRICE_W-1:0]  COST_TWO_RESET  = 10'd125;

  typedef enum logic [ACTION_W-1:0] {
    ACT_COIN    = 2'd0,
    ACT_CHANGE  = 2'd1,
    ACT_SELECT  = 2'd2,
    ACT_RESTOCK = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [COIN_W-1:0]    coin_cents;
    logic [SLOT_W-1:0]    slot;
    logic [QTY_W-1:0]     new_quantity;
    logic [PRICE_W-1:0]   new_price_cents;
  } item_t;

  typedef struct packed {
    logic                 change_valid;
    logic [REPORT_W-1:0]  change_cents;
    logic                 vend_valid;
    logic [SLOT_W-1:0]    vend_slot;
    logic [REPORT_W-1:0]  balance_cents;
    logic                 done_res;
  } result_t;

endpackage

// ----- rtl/vcc_if.sv -----
// ----------------------------------------------------------------------------
// vcc_item_if / vcc_result_if
// Valid/ready channels for requests into and results out of the controller.
// ----------------------------------------------------------------------------
interface vcc_item_if import vcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [COIN_W-1:0]    coin_cents;
  logic [SLOT_W-1:0]    slot;
  logic [QTY_W-1:0]     new_quantity;
  logic [PRICE_W-1:0]   new_price_cents;

  modport source (
    output valid, action, coin_cents, slot, new_quantity, new_price_cents,
    input  ready
  );
  modport sink (
    input  valid, action, coin_cents, slot, new_quantity, new_price_cents,
    output ready
  );
endinterface

interface vcc_result_if import vcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 change_valid;
  logic [REPORT_W-1:0]  change_cents;
  logic                 vend_valid;
  logic [SLOT_W-1:0]    vend_slot;
  logic [REPORT_W-1:0]  balance_cents;
  logic                 done_res;

  modport source (
    output valid, change_valid, change_cents, vend_valid, vend_slot,
           balance_cents, done_res,
    input  ready
  );
  modport sink (
    input  valid, change_valid, change_cents, vend_valid, vend_slot,
           balance_cents, done_res,
    output ready
  );
endinterface

// ----- rtl/vcc_in_reg.sv -----
// ----------------------------------------------------------------------------
// vcc_in_reg
// Input register: captures one request per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module vcc_in_reg import vcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  item_vld,
  output item_t item_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (advance) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item_q <= in_item;
    end
  end

endmodule

// ----- rtl/vcc_core.sv -----
// ----------------------------------------------------------------------------
// vcc_core
// Credit, stock and price registers with the single-pass update logic.
// ----------------------------------------------------------------------------
module vcc_core import vcc_pkg::*; #(
  parameter int unsigned BALANCE_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  localparam int unsigned WIDE_W = (BALANCE_BITS > REPORT_W) ? BALANCE_BITS : REPORT_W;
  localparam logic [BALANCE_BITS-1:0] CREDIT_MAX = {BALANCE_BITS{1'b1}};

  logic [BALANCE_BITS-1:0] credit, credit_next;
  logic [QTY_W-1:0]        stock_one, stock_one_next;
  logic [QTY_W-1:0]        stock_two, stock_two_next;
  logic [PRICE_W-1:0]      cost_one, cost_one_next;
  logic [PRICE_W-1:0]      cost_two, cost_two_next;

  logic [BALANCE_BITS:0]   coin_sum;
  logic                    coin_ok;
  logic [BALANCE_BITS-1:0] cost_ext;
  logic [QTY_W-1:0]        stock_sel;
  logic                    can_vend;
  logic [WIDE_W-1:0]       credit_wide, next_wide;
  logic [REPORT_W-1:0]     credit_rep, next_rep;

  assign coin_sum  = {1'b0, credit} + (BALANCE_BITS+1)'(item.coin_cents);
  assign coin_ok   = (item.coin_cents != '0) && (item.coin_cents < COIN_LIMIT);
  assign cost_ext  = BALANCE_BITS'((item.slot == SLOT_TWO) ? cost_two : cost_one);
  assign stock_sel = (item.slot == SLOT_TWO) ? stock_two : stock_one;
  assign can_vend  = ((item.slot == SLOT_ONE) || (item.slot == SLOT_TWO)) &&
                     (credit >= cost_ext) && (stock_sel != '0);

  // outputs report at most 16 bits, saturating a wider balance
  assign credit_wide = WIDE_W'(credit);
  assign next_wide   = WIDE_W'(credit_next);
  assign credit_rep  = (credit_wide > WIDE_W'(REPORT_MAX)) ? REPORT_MAX : credit_wide[REPORT_W-1:0];
  assign next_rep    = (next_wide > WIDE_W'(REPORT_MAX)) ? REPORT_MAX : next_wide[REPORT_W-1:0];

  always_comb begin
    credit_next    = credit;
    stock_one_next = stock_one;
    stock_two_next = stock_two;
    cost_one_next  = cost_one;
    cost_two_next  = cost_two;
    res            = '0;
    res.done_res   = 1'b1;
    unique case (item.action)
      ACT_COIN: begin
        if (coin_ok) begin
          credit_next = coin_sum[BALANCE_BITS] ? CREDIT_MAX : coin_sum[BALANCE_BITS-1:0];
        end
      end
      ACT_CHANGE: begin
        res.change_valid = 1'b1;
        res.change_cents = credit_rep;
        credit_next      = '0;
      end
      ACT_SELECT: begin
        if (can_vend) begin
          credit_next    = credit - cost_ext;
          res.vend_valid = 1'b1;
          res.vend_slot  = item.slot;
          if (item.slot == SLOT_ONE) begin
            stock_one_next = stock_one - QTY_W'(1);
          end else begin
            stock_two_next = stock_two - QTY_W'(1);
          end
        end
      end
      ACT_RESTOCK: begin
        res.done_res = 1'b0;
        if (item.slot == SLOT_ONE) begin
          stock_one_next = item.new_quantity;
          cost_one_next  = item.new_price_cents;
        end else if (item.slot == SLOT_TWO) begin
          stock_two_next = item.new_quantity;
          cost_two_next  = item.new_price_cents;
        end
      end
      default: ;
    endcase
    res.balance_cents = next_rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit    <= '0;
      stock_one <= STOCK_ONE_RESET;
      stock_two <= STOCK_TWO_RESET;
      cost_one  <= COST_ONE_RESET;
      cost_two  <= COST_TWO_RESET;
    end else if (fire) begin
      credit    <= credit_next;
      stock_one <= stock_one_next;
      stock_two <= stock_two_next;
      cost_one  <= cost_one_next;
      cost_two  <= cost_two_next;
    end
  end

endmodule

// ----- rtl/vcc_out_reg.sv -----
// ----------------------------------------------------------------------------
// vcc_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vcc_out_reg import vcc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_in_vld,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    advance,
  output logic    res_vld,
  output result_t res_q
);

  // whole pipeline moves when the result slot is free or being drained
  assign advance = !res_vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= res_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_in_vld) begin
      res_q <= res_in;
    end
  end

endmodule

// ----- rtl/vending_credit_controller_unit.sv -----
// ----------------------------------------------------------------------------
// vending_credit_controller_unit
// Two-slot vending controller keeping a credit balance, prices and stock.
// ----------------------------------------------------------------------------
// Requests arrive on the items channel (coin, return change, select, restock)
// and each one yields exactly one result on the results channel: change paid,
// slot vended, balance after the request and a done flag.
// The input register takes each request at the accepting edge, and the update
// logic then loads its result into the result register when the pipeline
// advances again.
// Throughput is one request per cycle while results drain; the limit is the
// single add, subtract or compare on the credit register, updated per request.
// Reset clears the credit to zero and loads the default stock (10 and 15) and
// prices (100 and 125 cents); both pipeline stages come up empty.
// When the receiver stalls, the result register holds its result and the
// input register holds its request; items.ready drops until results drain.
// Balances wider than 16 bits are reported saturated at 65535.
// ----------------------------------------------------------------------------
module vending_credit_controller_unit import vcc_pkg::*; #(
  parameter int unsigned BALANCE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  vcc_item_if.sink           items,
  vcc_result_if.source       results
);

  logic    advance;
  logic    item_vld;
  item_t   in_item;
  item_t   item_q;
  result_t res;
  result_t res_q;
  logic    res_vld;

  assign in_item.action          = action_t'(items.action);
  assign in_item.coin_cents      = items.coin_cents;
  assign in_item.slot            = items.slot;
  assign in_item.new_quantity    = items.new_quantity;
  assign in_item.new_price_cents = items.new_price_cents;

  assign items.ready = advance;

  vcc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (items.valid),
    .in_item  (in_item),
    .item_vld (item_vld),
    .item_q   (item_q)
  );

  vcc_core #(
    .BALANCE_BITS (BALANCE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance && item_vld),
    .item (item_q),
    .res  (res)
  );

  vcc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_in_vld (item_vld),
    .res_in     (res),
    .out_ready  (results.ready),
    .advance    (advance),
    .res_vld    (res_vld),
    .res_q      (res_q)
  );

  assign results.valid         = res_vld;
  assign results.change_valid  = res_q.change_valid;
  assign results.change_cents  = res_q.change_cents;
  assign results.vend_valid    = res_q.vend_valid;
  assign results.vend_slot     = res_q.vend_slot;
  assign results.balance_cents = res_q.balance_cents;
  assign results.done_res      = res_q.done_res;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vending credit controller: random and directed
// requests through the item channel, results scored against a local model.
// ----------------------------------------------------------------------------
module tb import vcc_pkg::*; ();

  localparam int unsigned BAL_BITS    = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam logic [BAL_BITS-1:0] CREDIT_MAX = {BAL_BITS{1'b1}};

  logic clk;
  logic rst;

  vcc_item_if   item_ch ();
  vcc_result_if res_ch ();

  vending_credit_controller_unit #(
    .BALANCE_BITS(BAL_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch.sink),
    .results (res_ch.source)
  );

  always #6 clk = ~clk;

  // model state
  logic [BAL_BITS-1:0] credit;
  logic [QTY_W-1:0]    stock1;
  logic [QTY_W-1:0]    stock2;
  logic [PRICE_W-1:0]  price1;
  logic [PRICE_W-1:0]  price2;

  item_t   pend_q[$];
  result_t expected_q[$];
  item_t   next_req;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pushed;
  int unsigned accepted;
  int unsigned mismatches;
  int unsigned n_results;
  int unsigned n_vends;
  int unsigned n_payouts;
  int unsigned n_sat;
  int unsigned idle_cycles;
  logic        item_taken;

  wire item_fire = item_ch.valid && item_ch.ready;
  wire res_fire  = res_ch.valid && res_ch.ready;

  function automatic logic [REPORT_W-1:0] clip16(logic [BAL_BITS-1:0] v);
    if (v > BAL_BITS'(REPORT_MAX)) return REPORT_MAX;
    return REPORT_W'(v);
  endfunction

  // advances the model by one request and returns the result it yields
  function automatic result_t vend_predict(item_t req);
    result_t r;
    logic [BAL_BITS:0] sum;
    r = '0;
    r.done_res = 1'b1;
    case (req.action)
      ACT_COIN: begin
        if (req.coin_cents != '0 && req.coin_cents < COIN_LIMIT) begin
          sum = {1'b0, credit} + (BAL_BITS+1)'(req.coin_cents);
          if (sum > {1'b0, CREDIT_MAX}) begin
            credit = CREDIT_MAX;
            n_sat++;
          end else begin
            credit = sum[BAL_BITS-1:0];
          end
        end
      end
      ACT_CHANGE: begin
        r.change_valid = 1'b1;
        r.change_cents = clip16(credit);
        credit = '0;
      end
      ACT_SELECT: begin
        if (req.slot == SLOT_ONE && credit >= BAL_BITS'(price1) && stock1 != '0) begin
          credit = credit - BAL_BITS'(price1);
          stock1 = stock1 - QTY_W'(1);
          r.vend_valid = 1'b1;
          r.vend_slot = SLOT_ONE;
        end else if (req.slot == SLOT_TWO && credit >= BAL_BITS'(price2) && stock2 != '0) begin
          credit = credit - BAL_BITS'(price2);
          stock2 = stock2 - QTY_W'(1);
          r.vend_valid = 1'b1;
          r.vend_slot = SLOT_TWO;
        end
      end
      default: begin
        r.done_res = 1'b0;
        if (req.slot == SLOT_ONE) begin
          stock1 = req.new_quantity;
          price1 = req.new_price_cents;
        end else if (req.slot == SLOT_TWO) begin
          stock2 = req.new_quantity;
          price2 = req.new_price_cents;
        end
      end
    endcase
    r.balance_cents = clip16(credit);
    return r;
  endfunction

  function automatic void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
    end
  endfunction

  function automatic item_t mk_req(action_t a, int unsigned coin, int unsigned slot,
                                   int unsigned qty, int unsigned price);
    item_t r;
    r.action          = a;
    r.coin_cents      = COIN_W'(coin);
    r.slot            = SLOT_W'(slot);
    r.new_quantity    = QTY_W'(qty);
    r.new_price_cents = PRICE_W'(price);
    return r;
  endfunction

  // mostly legal traffic, with some bad coins and unknown slots mixed in
  function automatic item_t rand_request();
    item_t r;
    int unsigned pick;
    r.action          = ACT_COIN;
    r.coin_cents      = COIN_W'($urandom);
    r.slot            = SLOT_W'($urandom_range(3));
    r.new_quantity    = QTY_W'($urandom);
    r.new_price_cents = PRICE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 38) begin
      if ($urandom_range(9) != 0) r.coin_cents = COIN_W'($urandom_range(1, 499));
    end else if (pick < 48) begin
      r.action = ACT_CHANGE;
    end else if (pick < 80) begin
      r.action = ACT_SELECT;
      if ($urandom_range(9) != 0) r.slot = SLOT_W'($urandom_range(1, 2));
    end else begin
      r.action = ACT_RESTOCK;
      if ($urandom_range(9) != 0) r.slot = SLOT_W'($urandom_range(1, 2));
      if ($urandom_range(7) != 0) r.new_quantity = QTY_W'($urandom_range(0, 6));
      if ($urandom_range(7) != 0) r.new_price_cents = PRICE_W'($urandom_range(0, 400));
    end
    return r;
  endfunction

  task automatic push_req(item_t r);
    pend_q.push_back(r);
    pushed++;
  endtask

  // sender holds off here until every request is scored
  task automatic drain();
    while (accepted != pushed || expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned n,
                           bit flood);
    int unsigned k;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    // long run of large coins drives the credit into saturation
    if (flood) begin
      for (k = 0; k < 135; k++) push_req(mk_req(ACT_COIN, $urandom_range(490, 499), 0, 0, 0));
      push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
      push_req(mk_req(ACT_COIN, 499, 0, 0, 0));
      push_req(mk_req(ACT_CHANGE, 0, 0, 0, 0));
    end
    for (k = 0; k < n; k++) push_req(rand_request());
    drain();
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!item_ch.valid || item_taken) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pend_q.pop_front();
          item_ch.action          <= next_req.action;
          item_ch.coin_cents      <= next_req.coin_cents;
          item_ch.slot            <= next_req.slot;
          item_ch.new_quantity    <= next_req.new_quantity;
          item_ch.new_price_cents <= next_req.new_price_cents;
          item_ch.valid           <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    item_t   req;
    result_t got;
    result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_fire;
      if (res_fire) begin
        got.change_valid  = res_ch.change_valid;
        got.change_cents  = res_ch.change_cents;
        got.vend_valid    = res_ch.vend_valid;
        got.vend_slot     = res_ch.vend_slot;
        got.balance_cents = res_ch.balance_cents;
        got.done_res      = res_ch.done_res;
        n_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request pending", $realtime);
        end else begin
          want = expected_q.pop_front();
          field_check("change_valid", want.change_valid, got.change_valid);
          field_check("change_cents", want.change_cents, got.change_cents);
          field_check("vend_valid", want.vend_valid, got.vend_valid);
          field_check("vend_slot", want.vend_slot, got.vend_slot);
          field_check("balance_cents", want.balance_cents, got.balance_cents);
          field_check("done_res", want.done_res, got.done_res);
          if (want.vend_valid) n_vends++;
          if (want.change_valid) n_payouts++;
        end
      end
      if (item_fire) begin
        req.action          = action_t'(item_ch.action);
        req.coin_cents      = item_ch.coin_cents;
        req.slot            = item_ch.slot;
        req.new_quantity    = item_ch.new_quantity;
        req.new_price_cents = item_ch.new_price_cents;
        expected_q.push_back(vend_predict(req));
        accepted++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if (item_fire || res_fire) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid           = 1'b0;
    item_ch.action          = '0;
    item_ch.coin_cents      = '0;
    item_ch.slot            = '0;
    item_ch.new_quantity    = '0;
    item_ch.new_price_cents = '0;
    res_ch.ready            = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pushed = 0; accepted = 0; mismatches = 0; n_results = 0;
    n_vends = 0; n_payouts = 0; n_sat = 0; idle_cycles = 0;
    credit = '0;
    stock1 = STOCK_ONE_RESET;
    stock2 = STOCK_TWO_RESET;
    price1 = COST_ONE_RESET;
    price2 = COST_TWO_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: empty-credit change, bad coins, unknown slots, stock-out
    push_req(mk_req(ACT_CHANGE, 0, 0, 0, 0));
    push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
    push_req(mk_req(ACT_COIN, 0, 0, 0, 0));
    push_req(mk_req(ACT_COIN, 500, 0, 0, 0));
    push_req(mk_req(ACT_COIN, 1023, 3, 127, 1023));
    push_req(mk_req(ACT_COIN, 1, 0, 0, 0));
    push_req(mk_req(ACT_COIN, 499, 0, 0, 0));
    push_req(mk_req(ACT_COIN, 100, 0, 0, 0));
    push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
    push_req(mk_req(ACT_SELECT, 0, 2, 0, 0));
    push_req(mk_req(ACT_SELECT, 0, 0, 0, 0));
    push_req(mk_req(ACT_SELECT, 1023, 3, 127, 1023));
    push_req(mk_req(ACT_RESTOCK, 0, 0, 127, 1023));
    push_req(mk_req(ACT_RESTOCK, 0, 3, 5, 5));
    push_req(mk_req(ACT_RESTOCK, 0, 1, 0, 1023));
    push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
    push_req(mk_req(ACT_RESTOCK, 0, 2, 127, 0));
    push_req(mk_req(ACT_SELECT, 0, 2, 0, 0));
    push_req(mk_req(ACT_RESTOCK, 0, 1, 1, 375));
    push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
    push_req(mk_req(ACT_SELECT, 0, 1, 0, 0));
    push_req(mk_req(ACT_CHANGE, 0, 0, 0, 0));
    push_req(mk_req(ACT_RESTOCK, 0, 2, 15, 125));
    drain();

    run_phase(0, 0, 100, 1'b0);
    run_phase(56, 0, 100, 1'b0);
    run_phase(0, 56, 100, 1'b0);
    run_phase(34, 34, 100, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results: %0d vends, %0d payouts, %0d saturating coins",
             accepted, n_results, n_vends, n_payouts, n_sat);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vcc_pkg.sv
rtl/vcc_if.sv
rtl/vcc_in_reg.sv
rtl/vcc_core.sv
rtl/vcc_out_reg.sv
rtl/vending_credit_controller_unit.sv
tb/tb.sv
